/* rtl/core/agx_pkg.sv */
`default_nettype none

package agx_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_ONE         = 65536;

    typedef logic [23:0] chan_t;   // linear radiance or gain
    typedef logic [24:0] mix_t;    // inset matrix output
    typedef logic [16:0] unit_t;   // Q16 value in [0,1]

    // Pipeline depths
    localparam int LOG2_STEPS = 16;
    localparam int LOG2_LAT   = LOG2_STEPS + 1;
    localparam int EXP_STEPS  = 16;
    localparam int POW_LAT    = LOG2_LAT + 2 + EXP_STEPS + 1;
    localparam int POLY_DEG   = 6;
    localparam int LANE_LAT   = LOG2_LAT + 2 + 2 * POLY_DEG + 1 + POW_LAT;
    localparam int SRGB_LAT   = POW_LAT + 2;
    localparam int PIPE_LAT   = 4 + LANE_LAT + 2 + SRGB_LAT;

    // Reciprocal multipliers use 30 fraction bits
    localparam int RECIP_SH = 30;
    localparam logic [29:0] DIV33_M = 30'(((64'd1 << RECIP_SH) + 64'd32) / 64'd33);

    // Matrices, Q16
    localparam logic [15:0] INSET_M [9] = '{
        16'd55213, 16'd5140,  16'd5192,
        16'd2774,  16'd57571, 16'd5188,
        16'd2777,  16'd5140,  16'd57616
    };
    localparam logic signed [17:0] OUTSET_M [9] = '{
        18'sd78439, -18'sd6424, -18'sd6490,
        -18'sd3467, 18'sd75491, -18'sd6486,
        -18'sd3472, -18'sd6425, 18'sd75437
    };

    // Log encoding and sigmoid polynomial
    localparam int LOG_ENC_OFS = 817491;
    localparam logic signed [23:0] POLY_P0 = 24'sd1015808;
    localparam logic signed [23:0] POLY_C [POLY_DEG] = '{
        -24'sd2630615, 24'sd2094531, -24'sd450101,
        24'sd28167, 24'sd7805, -24'sd152
    };

    // sRGB transfer curve
    localparam int SRGB_LIN_MAX  = 205;
    localparam int SRGB_LIN_GAIN = 846725;
    localparam int SRGB_POW_GAIN = 69140;
    localparam int SRGB_OFS      = 3604;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bv;
        v   = v_in;
        res = '0;
        bv  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bv > v) begin
                bv = bv >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bv != 0) begin
                if (v >= res + bv) begin
                    v   = v - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q30, by repeated square roots of one half
    function automatic logic [30:0] root_val(input int k);
        logic [63:0] r;
        r = 64'd1 << 29;
        for (int j = 1; j <= k; j++) begin
            r = isqrt64(r << 30);
        end
        return r[30:0];
    endfunction

    localparam logic [30:0] ROOT_TAB [0:16] = '{
        root_val(0),  root_val(1),  root_val(2),  root_val(3),
        root_val(4),  root_val(5),  root_val(6),  root_val(7),
        root_val(8),  root_val(9),  root_val(10), root_val(11),
        root_val(12), root_val(13), root_val(14), root_val(15),
        root_val(16)
    };

endpackage

`default_nettype wire

/* rtl/core/agx_tone_map_to_srgb8_core.sv */
// AgX tone mapper: linear RGB radiance in, 8-bit sRGB display codes out.
// Input channel s_*: one pixel per word, three 24-bit unsigned channels with
// FRAC_BITS fraction bits. Output channel m_*: one word of three 8-bit codes
// for every input word, in order. The user writes exposure_gain through
// cfg_wr_en/cfg_wr_data only while no pixel is in flight; the block itself
// does not enforce this. Reset loads unity gain. Throughput is one pixel per
// clock while the skid register is empty. Each channel path holds three
// 16-stage squaring chains and two 16-stage root-multiply chains for its
// log2/exp2 pipelines, plus the exposure, matrix, polynomial and sRGB stages.
// Each color channel runs in its own lane; the outset matrix merges lanes.
// When m_tready is low the finished word holds in the output register, the
// next word finishing lands in a skid register, and only then does s_tready
// drop and the whole pipeline hold. Reset clears all valid bits, including
// those of the output and skid registers; pixels in flight are dropped.
`default_nettype none

module agx_tone_map_to_srgb8_core
    import agx_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [23:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // red_in, green_in, blue_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // red_out, green_out, blue_out
);

    chan_t                gain_reg;
    logic                 pipe_en;
    logic                 s_accept;
    logic [PIPE_LAT-1:0]  vld_reg;
    logic                 pipe_out_v;

    logic [47:0]          xp_reg [3];
    logic [47:0]          xs_next [3];
    chan_t                e_reg  [3];
    logic [39:0]          ip_reg [9];
    logic [41:0]          isum_next [3];
    mix_t                 c_reg  [3];
    unit_t                d_lane [3];
    logic signed [35:0]   op_reg [9];
    logic signed [37:0]   osum_next [3];
    logic [37:0]          orn_next [3];
    unit_t                x_reg  [3];
    logic [7:0]           code_lane [3];

    logic                 m_tvalid_reg;
    logic [23:0]          m_data_reg;
    logic                 skid_v_reg;
    logic [23:0]          skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= 24'(Q_ONE);
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    // Advance everything unless the skid register is holding a word
    assign pipe_en    = !skid_v_reg;
    assign s_tready   = pipe_en;
    assign s_accept   = s_tvalid && s_tready;
    assign pipe_out_v = pipe_en && vld_reg[PIPE_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_accept};
        end
    end

    // Exposure and inset matrix
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            xs_next[k] = xp_reg[k] >> FRAC_BITS;
        end
        for (int k = 0; k < 3; k++) begin
            isum_next[k] = 42'(ip_reg[3*k]) + 42'(ip_reg[3*k+1]) + 42'(ip_reg[3*k+2])
                         + 42'd32768;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                xp_reg[k] <= 48'(s_tdata[24*k +: 24]) * 48'(gain_reg);
                e_reg[k]  <= (xs_next[k] > 48'hFF_FFFF) ? 24'hFF_FFFF : xs_next[k][23:0];
                c_reg[k]  <= isum_next[k][40:16];
            end
            for (int i = 0; i < 9; i++) begin
                ip_reg[i] <= 40'(e_reg[i % 3]) * 40'(INSET_M[i]);
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        agx_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk (aclk),
            .en   (pipe_en),
            .c    (c_reg[k]),
            .d    (d_lane[k])
        );
    end

    // Outset matrix merges the three lanes
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            osum_next[k] = 38'(op_reg[3*k]) + 38'(op_reg[3*k+1]) + 38'(op_reg[3*k+2]);
            orn_next[k]  = 38'(osum_next[k] + 38'sd32768) >> 16;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 9; i++) begin
                op_reg[i] <= 36'(OUTSET_M[i]) * 36'($signed({1'b0, d_lane[i % 3]}));
            end
            for (int k = 0; k < 3; k++) begin
                if (osum_next[k] <= 38'sd0) begin
                    x_reg[k] <= '0;
                end else if (orn_next[k] > 38'(Q_ONE)) begin
                    x_reg[k] <= 17'(Q_ONE);
                end else begin
                    x_reg[k] <= orn_next[k][16:0];
                end
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_srgb
        agx_srgb u_srgb (
            .aclk (aclk),
            .en   (pipe_en),
            .x    (x_reg[k]),
            .code (code_lane[k])
        );
    end

    // Output register with one skid word behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_v_reg   <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            if (skid_v_reg) begin
                m_tvalid_reg <= 1'b1;
                skid_v_reg   <= 1'b0;
            end else begin
                m_tvalid_reg <= pipe_out_v;
            end
        end else if (pipe_out_v) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            if (skid_v_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (pipe_out_v) begin
                m_data_reg <= {code_lane[2], code_lane[1], code_lane[0]};
            end
        end else if (pipe_out_v) begin
            skid_data_reg <= {code_lane[2], code_lane[1], code_lane[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> m_tvalid_reg)
        else $error("skid word held with empty output register");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("skid loaded without an output stall");

    a_stall_catch: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_out_v && m_tvalid_reg && !m_tready) |=> skid_v_reg)
        else $error("finished word lost during output stall");

    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_v_reg && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved while skid was full");

endmodule

`default_nettype wire

/* rtl/core/agx_log2.sv */
`default_nettype none

module agx_log2
    import agx_pkg::*;
#(
    parameter int IN_W = 25
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [IN_W-1:0]         v,
    output logic [$clog2(IN_W)+15:0]     log_q
);

    localparam int MSB_W = $clog2(IN_W);

    logic [MSB_W-1:0] msb_next;
    logic [30:0]      norm_next;
    logic [31:0]      sq_hi   [LOG2_STEPS];
    logic [30:0]      m_next  [LOG2_STEPS];
    logic [15:0]      frac_next [LOG2_STEPS];

    logic [30:0]      m_reg    [0:LOG2_STEPS];
    logic [15:0]      frac_reg [0:LOG2_STEPS];
    logic [MSB_W-1:0] msb_reg  [0:LOG2_STEPS];

    // Leading one and normalize the mantissa to [1,2) in Q30
    always_comb begin
        msb_next = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (v[i]) begin
                msb_next = MSB_W'(i);
            end
        end
        norm_next = 31'(v) << (6'd30 - 6'(msb_next));
    end

    // One fraction bit per squaring step
    always_comb begin
        for (int j = 0; j < LOG2_STEPS; j++) begin
            sq_hi[j]     = 32'((64'(m_reg[j]) * 64'(m_reg[j])) >> 30);
            m_next[j]    = sq_hi[j][31] ? sq_hi[j][31:1] : sq_hi[j][30:0];
            frac_next[j] = frac_reg[j];
            frac_next[j][15-j] = sq_hi[j][31];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]    <= norm_next;
            frac_reg[0] <= '0;
            msb_reg[0]  <= msb_next;
            for (int j = 0; j < LOG2_STEPS; j++) begin
                m_reg[j+1]    <= m_next[j];
                frac_reg[j+1] <= frac_next[j];
                msb_reg[j+1]  <= msb_reg[j];
            end
        end
    end

    assign log_q = {msb_reg[LOG2_STEPS], frac_reg[LOG2_STEPS]};

endmodule

`default_nettype wire

/* rtl/core/agx_pow.sv */
`default_nettype none

module agx_pow
    import agx_pkg::*;
#(
    parameter int NUM = 11,
    parameter int DEN = 5
) (
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire unit_t x,
    output unit_t      y
);

    localparam int LOG_W  = 21;
    localparam int WN_W   = LOG_W + $clog2(NUM + 1);
    localparam int SC_W   = WN_W + RECIP_SH;
    localparam int QW     = SC_W - RECIP_SH - 16;
    localparam int Q_MAX  = 17;
    localparam logic [29:0] RECIP =
        30'(((64'd1 << RECIP_SH) + 64'(DEN) - 64'd1) / 64'(DEN));
    localparam logic [LOG_W-1:0] W_ONE = LOG_W'(16 * Q_ONE);
    localparam logic [30:0] R_ONE = 31'd1 << 30;

    logic [LOG_W-1:0] log_q;
    logic [LOG_W-1:0] w_next;
    logic [WN_W-1:0]  wn_reg;
    logic [SC_W-1:0]  sc_reg;

    logic [30:0]   r_src [0:EXP_STEPS];
    logic [QW-1:0] q_src [0:EXP_STEPS];
    logic [15:0]   g_src [0:EXP_STEPS];
    logic [30:0]   r_next [EXP_STEPS];
    logic [61:0]   rp     [EXP_STEPS];
    logic [30:0]   r_reg  [EXP_STEPS];
    logic [QW-1:0] q_reg  [EXP_STEPS];
    logic [15:0]   g_reg  [EXP_STEPS];

    logic [5:0]    sh;
    logic [32:0]   rsum;
    unit_t         y_next;
    unit_t         y_reg;

    agx_log2 #(
        .IN_W (17)
    ) u_log2 (
        .aclk  (aclk),
        .en    (en),
        .v     (x),
        .log_q (log_q)
    );

    // x^(NUM/DEN) = 2^-(w*NUM/DEN), w = 16 - log2(x)
    assign w_next = W_ONE - log_q;

    always_ff @(posedge aclk) begin
        if (en) begin
            wn_reg <= WN_W'(WN_W'(w_next) * WN_W'(NUM));
            sc_reg <= SC_W'(wn_reg) * SC_W'(RECIP);
        end
    end

    always_comb begin
        r_src[0] = R_ONE;
        q_src[0] = sc_reg[SC_W-1:RECIP_SH+16];
        g_src[0] = sc_reg[RECIP_SH+15:RECIP_SH];
        for (int j = 0; j < EXP_STEPS; j++) begin
            r_src[j+1] = r_reg[j];
            q_src[j+1] = q_reg[j];
            g_src[j+1] = g_reg[j];
        end
        for (int j = 0; j < EXP_STEPS; j++) begin
            rp[j]     = 62'(r_src[j]) * 62'(ROOT_TAB[j+1]) + (62'd1 << 29);
            r_next[j] = g_src[j][15-j] ? 31'(rp[j] >> 30) : r_src[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < EXP_STEPS; j++) begin
                r_reg[j] <= r_next[j];
                q_reg[j] <= q_src[j];
                g_reg[j] <= g_src[j];
            end
        end
    end

    // Integer part of the exponent: rounded right shift
    always_comb begin
        sh     = 6'd14 + 6'(q_src[EXP_STEPS]);
        rsum   = 33'(r_src[EXP_STEPS]) + (33'd1 << (sh - 6'd1));
        y_next = 17'(rsum >> sh);
        if (q_src[EXP_STEPS] > QW'(Q_MAX)) begin
            y_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

/* rtl/core/agx_lane.sv */
`default_nettype none

module agx_lane
    import agx_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic en,
    input  wire mix_t c,
    output unit_t     d
);

    localparam logic signed [23:0] NUM_OFS = 24'(LOG_ENC_OFS - FRAC_BITS * Q_ONE);

    logic [20:0]          log_q;
    logic                 zd_reg [LOG2_LAT];
    logic signed [23:0]   num_next;
    logic [22:0]          x2_reg;
    logic                 e1_z_reg;
    logic [52:0]          p33_reg;
    logic                 e2_z_reg;
    unit_t                t_first;

    logic signed [23:0]   p_src [POLY_DEG];
    unit_t                t_src [POLY_DEG];
    logic                 z_src [POLY_DEG];
    logic signed [41:0]   qt    [POLY_DEG];
    logic signed [41:0]   pm_reg [POLY_DEG];
    unit_t                tm_reg [POLY_DEG];
    logic                 zm_reg [POLY_DEG];
    logic signed [23:0]   pa_reg [POLY_DEG];
    unit_t                ta_reg [POLY_DEG];
    logic                 za_reg [POLY_DEG];

    unit_t                pin_next;
    unit_t                pin_reg;

    agx_log2 #(
        .IN_W (25)
    ) u_log2 (
        .aclk  (aclk),
        .en    (en),
        .v     (c),
        .log_q (log_q)
    );

    // A zero channel encodes as zero; carry the flag beside the log2 unit
    always_ff @(posedge aclk) begin
        if (en) begin
            zd_reg[0] <= (c == '0);
            for (int i = 1; i < LOG2_LAT; i++) begin
                zd_reg[i] <= zd_reg[i-1];
            end
        end
    end

    assign num_next = $signed({3'b000, log_q}) + NUM_OFS;

    // t = 2*num/33 by reciprocal multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg   <= (num_next > 24'sd0) ? {num_next[21:0], 1'b0} : '0;
            e1_z_reg <= zd_reg[LOG2_LAT-1];
            p33_reg  <= 53'(x2_reg) * 53'(DIV33_M);
            e2_z_reg <= e1_z_reg;
        end
    end

    assign t_first = (p33_reg[52:30] > 23'(Q_ONE)) ? 17'(Q_ONE) : p33_reg[46:30];

    // Horner steps: multiply, then truncate toward zero and add
    always_comb begin
        p_src[0] = POLY_P0;
        t_src[0] = t_first;
        z_src[0] = e2_z_reg;
        for (int i = 1; i < POLY_DEG; i++) begin
            p_src[i] = pa_reg[i-1];
            t_src[i] = ta_reg[i-1];
            z_src[i] = za_reg[i-1];
        end
        for (int i = 0; i < POLY_DEG; i++) begin
            qt[i] = pm_reg[i][41] ? ((pm_reg[i] + 42'sd65535) >>> 16) : (pm_reg[i] >>> 16);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < POLY_DEG; i++) begin
                pm_reg[i] <= p_src[i] * $signed({1'b0, t_src[i]});
                tm_reg[i] <= t_src[i];
                zm_reg[i] <= z_src[i];
                pa_reg[i] <= 24'(qt[i] + 42'(POLY_C[i]));
                ta_reg[i] <= tm_reg[i];
                za_reg[i] <= zm_reg[i];
            end
        end
    end

    // Clamp to [1,65536]; the power of one lands on zero
    always_comb begin
        if (za_reg[POLY_DEG-1] || pa_reg[POLY_DEG-1] <= 24'sd0) begin
            pin_next = 17'd1;
        end else if (pa_reg[POLY_DEG-1] > 24'sd65536) begin
            pin_next = 17'(Q_ONE);
        end else begin
            pin_next = 17'(pa_reg[POLY_DEG-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pin_reg <= pin_next;
        end
    end

    agx_pow #(
        .NUM (11),
        .DEN (5)
    ) u_pow (
        .aclk (aclk),
        .en   (en),
        .x    (pin_reg),
        .y    (d)
    );

endmodule

`default_nettype wire

/* rtl/core/agx_srgb.sv */
`default_nettype none

module agx_srgb
    import agx_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire unit_t x,
    output logic [7:0] code
);

    unit_t              pw;
    unit_t              xd_reg [POW_LAT];
    logic               lin_next;
    logic [36:0]        prod_reg;
    logic               lin_reg;
    logic signed [21:0] s_next;
    unit_t              s_clamp;
    logic [7:0]         code_reg;

    agx_pow #(
        .NUM (5),
        .DEN (12)
    ) u_pow (
        .aclk (aclk),
        .en   (en),
        .x    (x),
        .y    (pw)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            xd_reg[0] <= x;
            for (int i = 1; i < POW_LAT; i++) begin
                xd_reg[i] <= xd_reg[i-1];
            end
        end
    end

    assign lin_next = (xd_reg[POW_LAT-1] <= 17'(SRGB_LIN_MAX));

    // Share one multiplier between the linear toe and the power segment
    always_ff @(posedge aclk) begin
        if (en) begin
            lin_reg  <= lin_next;
            prod_reg <= lin_next ? 37'(xd_reg[POW_LAT-1]) * 37'(SRGB_LIN_GAIN)
                                 : 37'(pw) * 37'(SRGB_POW_GAIN);
        end
    end

    always_comb begin
        s_next = $signed({1'b0, prod_reg[36:16]});
        if (!lin_reg) begin
            s_next = s_next - 22'(SRGB_OFS);
        end
        if (s_next < 22'sd0) begin
            s_clamp = '0;
        end else if (s_next > 22'sd65536) begin
            s_clamp = 17'(Q_ONE);
        end else begin
            s_clamp = 17'(s_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            code_reg <= 8'((25'(s_clamp) * 25'd255 + 25'd32768) >> 16);
        end
    end

    assign code = code_reg;

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb
    import agx_pkg::*;
();

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 150;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [23:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    agx_tone_map_to_srgb8_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // predictor state
    logic [23:0] gain_shadow;
    logic [63:0] root_q30 [0:16];
    logic [23:0] expected_codes [$];

    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    int idle_count;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bv;
        v   = v_in;
        res = 0;
        bv  = 64'd1 << 62;
        while (bv > v) bv = bv >> 2;
        while (bv != 0) begin
            if (v >= res + bv) begin
                v   = v - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_q16(input logic [63:0] v);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        msb  = 0;
        frac = 0;
        while (msb < 40 && (v >> (msb + 1)) != 0) msb++;
        m = v << (30 - msb);
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m       = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(msb) << 16) + frac;
    endfunction

    function automatic logic [63:0] exp2_neg(input logic [63:0] w);
        logic [63:0] q;
        logic [63:0] g;
        logic [63:0] r;
        int          sh;
        q = w >> 16;
        g = w & 64'hFFFF;
        r = 64'd1 << 30;
        if (q > 40) return 0;
        for (int k = 1; k <= 16; k++)
            if ((g >> (16 - k)) & 1) r = (r * root_q30[k] + (64'd1 << 29)) >> 30;
        sh = 14 + int'(q);
        return (r + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [63:0] pow_q16(input logic [63:0] x, input int pn, input int pd);
        logic [63:0] w;
        w = (64'd16 << 16) - log2_q16(x);
        return exp2_neg(w * pn / pd);
    endfunction

    function automatic longint poly_mul(input longint p, input longint t);
        return (p * t) / 65536;
    endfunction

    function automatic logic [63:0] sigmoid_lane(input logic [63:0] c);
        longint num;
        longint t;
        longint p;
        if (c == 0) return 0;
        num = longint'(log2_q16(c)) + LOG_ENC_OFS - longint'(FRAC_BITS_DEF) * 65536;
        if (num <= 0) t = 0;
        else begin
            t = num * 2 / 33;
            if (t > 65536) t = 65536;
        end
        p = 1015808;
        p = poly_mul(p, t) - 2630615;
        p = poly_mul(p, t) + 2094531;
        p = poly_mul(p, t) - 450101;
        p = poly_mul(p, t) + 28167;
        p = poly_mul(p, t) + 7805;
        p = poly_mul(p, t) - 152;
        if (p <= 0) return 0;
        if (p > 65536) p = 65536;
        return pow_q16(64'(p), 11, 5);
    endfunction

    function automatic logic [7:0] srgb_encode(input logic [63:0] x);
        longint      s;
        logic [63:0] code;
        if (x <= SRGB_LIN_MAX) s = longint'((x * SRGB_LIN_GAIN) >> 16);
        else s = longint'((64'(SRGB_POW_GAIN) * pow_q16(x, 5, 12)) >> 16) - SRGB_OFS;
        if (s < 0) s = 0;
        if (s > 65536) s = 65536;
        code = (64'(s) * 255 + 32768) >> 16;
        return code[7:0];
    endfunction

    function automatic logic [23:0] tone_map_pixel(input logic [71:0] px);
        logic [63:0] e [3];
        logic [63:0] d [3];
        logic [63:0] p;
        logic [63:0] acc;
        longint      sacc;
        logic [63:0] x;
        logic [23:0] codes;
        for (int k = 0; k < 3; k++) begin
            p    = (64'(px[24*k +: 24]) * 64'(gain_shadow)) >> FRAC_BITS_DEF;
            e[k] = p > 64'hFFFFFF ? 64'hFFFFFF : p;
        end
        for (int k = 0; k < 3; k++) begin
            acc = 32768;
            for (int j = 0; j < 3; j++) acc += 64'(INSET_M[k*3+j]) * e[j];
            d[k] = sigmoid_lane(acc >> 16);
        end
        for (int k = 0; k < 3; k++) begin
            sacc = 0;
            for (int j = 0; j < 3; j++) sacc += longint'(OUTSET_M[k*3+j]) * longint'(d[j]);
            if (sacc <= 0) x = 0;
            else begin
                x = (64'(sacc) + 32768) >> 16;
                if (x > 65536) x = 65536;
            end
            codes[8*k +: 8] = srgb_encode(x);
        end
        return codes;
    endfunction

    // keep tvalid high after an accepted word; idle and drain phases drop it
    task automatic send_pixel(input logic [23:0] r, input logic [23:0] g, input logic [23:0] b);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_codes = {expected_codes, tone_map_pixel({b, g, r})};
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [23:0] g);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        gain_shadow = g;
    endtask

    function automatic logic [23:0] rand_chan();
        case ($urandom_range(5, 0))
            0:       return 24'($urandom_range(255, 0));
            1:       return 24'($urandom_range(65535, 0));
            2:       return 24'($urandom_range(1 << 20, 0));
            3:       return 24'hFFFFFF - 24'($urandom_range(255, 0));
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic test_directed();
        logic [23:0] edge_vals [6];
        edge_vals = '{24'd0, 24'd1, 24'd205, 24'd65536, 24'h7FFFFF, 24'hFFFFFF};
        foreach (edge_vals[i]) send_pixel(edge_vals[i], edge_vals[i], edge_vals[i]);
        send_pixel(24'hFFFFFF, 24'd0, 24'd0);
        send_pixel(24'd0, 24'hFFFFFF, 24'd0);
        send_pixel(24'd0, 24'd0, 24'hFFFFFF);
        send_pixel(24'd3, 24'd0, 24'd1);
        send_pixel(24'd65536, 24'd0, 24'd0);
        send_pixel(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        send_pixel(24'h555555, 24'hAAAAAA, 24'h555555);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic test_gains();
        logic [23:0] gains [5];
        gains = '{24'd0, 24'hFFFFFF, 24'd1, 24'd4096, 24'd1 << 20};
        foreach (gains[i]) begin
            write_gain(gains[i]);
            send_pixel(24'd65536, 24'd65536, 24'd65536);
            test_random(60);
        end
        write_gain(24'($urandom()));
        test_random(60);
        write_gain(24'd65536);
    endtask

    task automatic test_idling();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(150);
        send_idle_pct = 53; recv_stall_pct = 0;  test_random(150);
        send_idle_pct = 0;  recv_stall_pct = 53; test_random(150);
        send_idle_pct = 9;  recv_stall_pct = 9;  test_random(150);
        send_idle_pct = 0;  recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        // fill the pipeline and skid while the output holds off
        hold_off = 1'b1;
        test_random(130);
        hold_off = 1'b0;
        wait_drained();
    endtask

    // receiver ready: long hold-off counted here, else random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            idle_count <= 0;
        end else if (hold_off && idle_count < 600) begin
            m_tready   <= 1'b0;
            idle_count <= idle_count + 1;
        end else begin
            if (!hold_off) idle_count <= 0;
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    logic [23:0] want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_tdata);
            end else begin
                want = expected_codes.pop_front();
                for (int k = 0; k < 3; k++)
                    if (m_tdata[8*k +: 8] !== want[8*k +: 8]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("channel %0d: expected %0d got %0d",
                                     k, want[8*k +: 8], m_tdata[8*k +: 8]);
                    end
            end
        end
    end

    int quiet_cycles;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_CYCLES) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        gain_shadow    = 24'd65536;
        root_q30[0]    = 64'd1 << 29;
        for (int k = 1; k <= 16; k++) root_q30[k] = sqrt_floor(root_q30[k-1] << 30);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_gains();
        test_idling();
        test_backpressure();
        wait_drained();
        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
